@@ rtl/core/utfct_pkg.sv @@
// shared types, codes and constants of the utf charset transcoder
package utfct_pkg;

  // conversion modes held in the configuration register
  localparam logic [1:0] MODE_COPY    = 2'd0;
  localparam logic [1:0] MODE_LATIN1  = 2'd1;
  localparam logic [1:0] MODE_UTF8_IN = 2'd2;
  localparam logic [1:0] MODE_UTF16_IN = 2'd3;

  // error codes on the result channel
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_ILLEGAL    = 2'd1;
  localparam logic [1:0] ERR_INCOMPLETE = 2'd2;

  // width of a decoded code point
  localparam int unsigned CpW = 21;

  // input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_req_t;

  // result request
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] error_code;
    logic       last_of_run;
  } out_res_t;

  // what the back end has to emit for one classified input
  typedef enum logic [1:0] {
    PK_RAW   = 2'd0,
    PK_UTF8  = 2'd1,
    PK_UTF16 = 2'd2,
    PK_ERROR = 2'd3
  } pkt_kind_t;

  typedef struct packed {
    pkt_kind_t        kind;
    logic [1:0]       err;
    logic [CpW-1:0]   value;
  } pkt_t;

  // front to queue
  typedef struct packed {
    logic push;
    pkt_t pkt;
  } q_push_t;

  // queue to back
  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } q_head_t;

endpackage

@@ rtl/core/utfct_front.sv @@
// front end: configuration, sequence state and classification of input bytes
module utfct_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data,
  input  logic                in_valid,
  input  utfct_pkg::in_req_t  in_req,
  input  logic                q_full,
  output logic                in_stall,
  output utfct_pkg::q_push_t  q_push
);

  logic [1:0]  mode_r;
  logic [23:0] held_bytes_r, held_bytes_nxt;
  logic [1:0]  held_count_r, held_count_nxt;
  logic [2:0]  seq_len_r, seq_len_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        eob;
  logic        complete;
  logic [15:0] unit;
  logic [20:0] d2, d3, d4, pair_cp;
  logic        has_res;
  utfct_pkg::pkt_t pkt;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_req.data_byte;
  assign eob      = in_req.end_of_buffer;

  // candidate values for each sequence shape
  assign complete = ({1'b0, held_count_r} + 3'd1) >= seq_len_r;
  assign unit     = {held_bytes_r[7:0], b};
  assign d2       = {10'd0, held_bytes_r[4:0], b[5:0]};
  assign d3       = {5'd0, held_bytes_r[11:8], held_bytes_r[5:0], b[5:0]};
  assign d4       = {held_bytes_r[18:16], held_bytes_r[13:8], held_bytes_r[5:0], b[5:0]};
  assign pair_cp  = 21'h010000 + {1'b0, held_bytes_r[17:8], held_bytes_r[1:0], b};

  // classify the byte and advance the open sequence
  always_comb begin
    held_bytes_nxt = held_bytes_r;
    held_count_nxt = held_count_r;
    seq_len_nxt    = seq_len_r;
    has_res        = 1'b0;
    pkt.kind       = utfct_pkg::PK_RAW;
    pkt.err        = utfct_pkg::ERR_NONE;
    pkt.value      = {13'd0, b};
    unique case (mode_r)
      utfct_pkg::MODE_COPY: begin
        has_res = 1'b1;
      end
      utfct_pkg::MODE_LATIN1: begin
        has_res  = 1'b1;
        pkt.kind = utfct_pkg::PK_UTF8;
      end
      utfct_pkg::MODE_UTF8_IN: begin
        if (seq_len_r == 3'd0) begin
          if (b[7] == 1'b0) begin
            has_res  = 1'b1;
            pkt.kind = utfct_pkg::PK_UTF16;
          end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            held_bytes_nxt = {16'd0, b};
            held_count_nxt = 2'd1;
            if (b[7:5] == 3'b110) begin
              seq_len_nxt = 3'd2;
            end else if (b[7:4] == 4'b1110) begin
              seq_len_nxt = 3'd3;
            end else begin
              seq_len_nxt = 3'd4;
            end
            if (eob) begin
              has_res  = 1'b1;
              pkt.kind = utfct_pkg::PK_ERROR;
              pkt.err  = utfct_pkg::ERR_INCOMPLETE;
            end
          end else begin
            has_res  = 1'b1;
            pkt.kind = utfct_pkg::PK_ERROR;
            pkt.err  = utfct_pkg::ERR_ILLEGAL;
          end
        end else if (!complete) begin
          held_bytes_nxt = {held_bytes_r[15:0], b};
          held_count_nxt = held_count_r + 2'd1;
          if (eob) begin
            has_res  = 1'b1;
            pkt.kind = utfct_pkg::PK_ERROR;
            pkt.err  = utfct_pkg::ERR_INCOMPLETE;
          end
        end else begin
          // sequence complete: check continuations and value range
          has_res  = 1'b1;
          pkt.kind = utfct_pkg::PK_UTF16;
          case (seq_len_r)
            3'd2: begin
              pkt.value = d2;
              if (b[7:6] != 2'b10 || d2 < 21'h80) begin
                pkt.kind = utfct_pkg::PK_ERROR;
              end
            end
            3'd3: begin
              pkt.value = d3;
              if (held_bytes_r[7:6] != 2'b10 || b[7:6] != 2'b10 || d3 < 21'h800 ||
                  (d3 >= 21'hD800 && d3 <= 21'hDFFF)) begin
                pkt.kind = utfct_pkg::PK_ERROR;
              end
            end
            default: begin
              pkt.value = d4;
              if (held_bytes_r[15:14] != 2'b10 || held_bytes_r[7:6] != 2'b10 ||
                  b[7:6] != 2'b10 || d4 < 21'h10000 || d4 > 21'h10FFFF) begin
                pkt.kind = utfct_pkg::PK_ERROR;
              end
            end
          endcase
          if (pkt.kind == utfct_pkg::PK_ERROR) begin
            pkt.err = utfct_pkg::ERR_ILLEGAL;
          end
        end
      end
      utfct_pkg::MODE_UTF16_IN: begin
        if (seq_len_r == 3'd0) begin
          held_bytes_nxt = {16'd0, b};
          held_count_nxt = 2'd1;
          seq_len_nxt    = 3'd2;
          if (eob) begin
            has_res  = 1'b1;
            pkt.kind = utfct_pkg::PK_ERROR;
            pkt.err  = utfct_pkg::ERR_INCOMPLETE;
          end
        end else if (!complete) begin
          held_bytes_nxt = {held_bytes_r[15:0], b};
          held_count_nxt = held_count_r + 2'd1;
          if (eob) begin
            has_res  = 1'b1;
            pkt.kind = utfct_pkg::PK_ERROR;
            pkt.err  = utfct_pkg::ERR_INCOMPLETE;
          end
        end else if (seq_len_r == 3'd2) begin
          if (unit[15:10] == 6'b110110) begin
            // high surrogate: wait for the low half
            held_bytes_nxt = {8'd0, unit};
            held_count_nxt = 2'd2;
            seq_len_nxt    = 3'd4;
            if (eob) begin
              has_res  = 1'b1;
              pkt.kind = utfct_pkg::PK_ERROR;
              pkt.err  = utfct_pkg::ERR_INCOMPLETE;
            end
          end else if (unit[15:10] == 6'b110111) begin
            has_res  = 1'b1;
            pkt.kind = utfct_pkg::PK_ERROR;
            pkt.err  = utfct_pkg::ERR_ILLEGAL;
          end else begin
            has_res   = 1'b1;
            pkt.kind  = utfct_pkg::PK_UTF8;
            pkt.value = {5'd0, unit};
          end
        end else begin
          // surrogate pair joined
          has_res = 1'b1;
          if (held_bytes_r[7:2] == 6'b110111 && held_bytes_r[23:18] == 6'b110110) begin
            pkt.kind  = utfct_pkg::PK_UTF8;
            pkt.value = pair_cp;
          end else begin
            pkt.kind = utfct_pkg::PK_ERROR;
            pkt.err  = utfct_pkg::ERR_ILLEGAL;
          end
        end
      end
    endcase
    // any result ends the open sequence
    if (has_res) begin
      held_bytes_nxt = '0;
      held_count_nxt = '0;
      seq_len_nxt    = '0;
    end
  end

  assign q_push.push = accept && has_res;
  assign q_push.pkt  = pkt;

  // mode register and sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= utfct_pkg::MODE_COPY;
      held_bytes_r <= '0;
      held_count_r <= '0;
      seq_len_r    <= '0;
    end else if (cfg_wr_en) begin
      mode_r       <= cfg_wr_data;
      held_bytes_r <= '0;
      held_count_r <= '0;
      seq_len_r    <= '0;
    end else if (accept) begin
      held_bytes_r <= held_bytes_nxt;
      held_count_r <= held_count_nxt;
      seq_len_r    <= seq_len_nxt;
    end
  end

  // no bytes held without an open sequence
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    seq_len_r == 3'd0 |-> held_count_r == 2'd0)
    else $error("bytes held with no open sequence");

  // an open sequence always has room for its completing byte
  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    seq_len_r != 3'd0 |-> ({1'b0, held_count_r} < seq_len_r && held_count_r != 2'd0))
    else $error("held count out of step with sequence length");

endmodule

@@ rtl/core/utfct_queue.sv @@
// two-entry queue of classified requests between front and back end
module utfct_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  utfct_pkg::q_push_t  q_push,
  input  logic                pop,
  output logic                full,
  output utfct_pkg::q_head_t  q_head
);

  utfct_pkg::pkt_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full         = count_r == 2'd2;
  assign q_head.valid = count_r != 2'd0;
  assign q_head.pkt   = entry_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (q_push.push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!q_push.push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (q_push.push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (q_push.push) begin
      entry_r[wr_ptr_r] <= q_push.pkt;
    end
  end

  // no overflow or underflow
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_head.valid)
    else $error("pop from empty queue");

endmodule

@@ rtl/core/utfct_back.sv @@
// back end: encodes each queued request and emits it one byte per cycle while out_stall is low
module utfct_back (
  input  logic                clk,
  input  logic                rst_n,
  input  utfct_pkg::q_head_t  q_head,
  output logic                pop,
  input  logic                out_stall,
  output logic                out_valid,
  output utfct_pkg::out_res_t out_res
);

  logic                out_valid_r;
  utfct_pkg::out_res_t out_res_r, out_res_nxt;
  logic [1:0]          idx_r;
  logic [2:0]          n_bytes;
  logic [7:0]          enc [4];
  logic [20:0]         cp;
  logic [19:0]         sv;
  logic                load;
  logic                last;

  assign cp = q_head.pkt.value;
  assign sv = {cp[19:16] - 4'd1, cp[15:0]};

  // byte count and byte values for the head request
  always_comb begin
    n_bytes = 3'd1;
    enc[0]  = cp[7:0];
    enc[1]  = 8'd0;
    enc[2]  = 8'd0;
    enc[3]  = 8'd0;
    unique case (q_head.pkt.kind)
      utfct_pkg::PK_RAW: begin
        n_bytes = 3'd1;
      end
      utfct_pkg::PK_UTF8: begin
        if (cp <= 21'h7F) begin
          n_bytes = 3'd1;
        end else if (cp <= 21'h7FF) begin
          n_bytes = 3'd2;
          enc[0]  = {3'b110, cp[10:6]};
          enc[1]  = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
          n_bytes = 3'd3;
          enc[0]  = {4'b1110, cp[15:12]};
          enc[1]  = {2'b10, cp[11:6]};
          enc[2]  = {2'b10, cp[5:0]};
        end else begin
          n_bytes = 3'd4;
          enc[0]  = {5'b11110, cp[20:18]};
          enc[1]  = {2'b10, cp[17:12]};
          enc[2]  = {2'b10, cp[11:6]};
          enc[3]  = {2'b10, cp[5:0]};
        end
      end
      utfct_pkg::PK_UTF16: begin
        if (cp <= 21'hFFFF) begin
          n_bytes = 3'd2;
          enc[0]  = cp[15:8];
          enc[1]  = cp[7:0];
        end else begin
          n_bytes = 3'd4;
          enc[0]  = {6'b110110, sv[19:18]};
          enc[1]  = sv[17:10];
          enc[2]  = {6'b110111, sv[9:8]};
          enc[3]  = sv[7:0];
        end
      end
      utfct_pkg::PK_ERROR: begin
        n_bytes = 3'd1;
        enc[0]  = 8'd0;
      end
    endcase
  end

  // output register loads when empty or being taken
  assign load = q_head.valid && (!out_valid_r || !out_stall);
  assign last = ({1'b0, idx_r} + 3'd1) == n_bytes;
  assign pop  = load && last;

  always_comb begin
    out_res_nxt.last_of_run = last;
    if (q_head.pkt.kind == utfct_pkg::PK_ERROR) begin
      out_res_nxt.out_byte   = 8'd0;
      out_res_nxt.byte_valid = 1'b0;
      out_res_nxt.error_code = q_head.pkt.err;
    end else begin
      out_res_nxt.out_byte   = enc[idx_r];
      out_res_nxt.byte_valid = 1'b1;
      out_res_nxt.error_code = utfct_pkg::ERR_NONE;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= last ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // a request stays at the head until its last byte is loaded
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd0 |-> q_head.valid)
    else $error("byte index advanced without a head request");

  // error results are single and carry a code
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.byte_valid |->
      out_res_r.last_of_run && out_res_r.error_code != utfct_pkg::ERR_NONE)
    else $error("malformed error result");

endmodule

@@ rtl/core/utf_charset_transcoder.sv @@
// top level of the utf charset transcoder
//
// Input channel in_valid/in_stall/in_req carries one source byte per request
// with an end-of-buffer flag. Output channel out_valid/out_stall/out_res
// carries one result per request: a converted byte, or an error code
// (illegal or incomplete sequence) with last_of_run set. cfg_wr_en and
// cfg_wr_data write the 2-bit conversion mode and close any open sequence.
// A front end keeps the open sequence and classifies each byte; a two-entry
// queue feeds a back end that encodes and sends one result per cycle while
// out_stall is low. A taken byte's first result is registered in the queue
// and then in the byte-wide output register, which sends the results of a
// byte one at a time; bytes that only extend a sequence are taken every
// cycle while the queue has room.
// Reset (rst_n low, synchronous) selects copy mode, closes the sequence and
// empties the queue and output register. When the receiver stalls, the
// output holds its result, the queue fills and in_stall rises.
module utf_charset_transcoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  utfct_pkg::in_req_t  in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output utfct_pkg::out_res_t out_res
);

  utfct_pkg::q_push_t q_push;
  utfct_pkg::q_head_t q_head;
  logic               q_full;
  logic               q_pop;

  // classification and sequence state
  utfct_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_req      (in_req),
    .q_full      (q_full),
    .in_stall    (in_stall),
    .q_push      (q_push)
  );

  // decoupling queue
  utfct_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .full   (q_full),
    .q_head (q_head)
  );

  // encoding and output
  utfct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .pop       (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

@@ sim/utf_charset_transcoder_tb.sv @@
// self-checking testbench for the utf charset transcoder
`timescale 1ns / 1ps

module utf_charset_transcoder_tb;
  import utfct_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BYTES  = 31;
  localparam int SETTLE       = 12;

  logic     clk;
  logic     rst_n       = 1'b0;
  logic     cfg_wr_en   = 1'b0;
  logic [1:0] cfg_wr_data = MODE_COPY;
  logic     in_valid    = 1'b0;
  logic     in_stall;
  in_req_t  in_req      = '0;
  logic     out_valid;
  logic     out_stall   = 1'b0;
  out_res_t out_res;

  utf_charset_transcoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  // source bytes waiting for the driver, results still owed by the block
  in_req_t  pending_bytes[$];
  out_res_t expected_q[$];
  out_res_t byte_results[$];

  int bytes_queued = 0;
  int bytes_taken  = 0;
  int fail_count   = 0;
  int cycle_cnt    = 0;

  bit in_fire  = 1'b0;
  bit out_fire = 1'b0;
  int in_gap   = 0;
  int out_wait = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_on   = 1'b0;
  int hold_left = 0;

  // transcoder state as predicted
  logic [1:0]  cur_mode = MODE_COPY;
  logic [23:0] seq_bytes = '0;
  logic [1:0]  seq_held = '0;
  logic [2:0]  seq_total = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- prediction ----------------

  function automatic void close_seq();
    seq_bytes = '0;
    seq_held  = '0;
    seq_total = '0;
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    out_res_t r;
    r.out_byte    = b;
    r.byte_valid  = 1'b1;
    r.error_code  = ERR_NONE;
    r.last_of_run = 1'b0;
    byte_results.push_back(r);
  endfunction

  // an error replaces any result and closes the open sequence
  function automatic void emit_error(logic [1:0] code);
    out_res_t r;
    close_seq();
    r.out_byte    = 8'h00;
    r.byte_valid  = 1'b0;
    r.error_code  = code;
    r.last_of_run = 1'b1;
    byte_results.delete();
    byte_results.push_back(r);
  endfunction

  function automatic void emit_utf8(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      emit_byte(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      emit_byte({3'b110, cp[10:6]});
      emit_byte({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      emit_byte({4'b1110, cp[15:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end else begin
      emit_byte({5'b11110, cp[20:18]});
      emit_byte({2'b10, cp[17:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end
  endfunction

  // hold one more byte; returns 1 when this byte completes the sequence
  function automatic bit extend_seq(logic [7:0] b);
    if (int'(seq_held) + 1 >= int'(seq_total)) return 1'b1;
    seq_bytes = {seq_bytes[15:0], b};
    seq_held  = seq_held + 2'd1;
    return 1'b0;
  endfunction

  function automatic void decode_utf8(logic [7:0] b, logic eob);
    logic [7:0]  s[4];
    logic [20:0] cp;
    logic [19:0] v;
    int n;
    bit bad;
    if (seq_total == 0) begin
      if (b < 8'h80) begin
        emit_byte(8'h00);
        emit_byte(b);
        return;
      end
      if (b[7:5] == 3'b110) seq_total = 3'd2;
      else if (b[7:4] == 4'b1110) seq_total = 3'd3;
      else if (b[7:3] == 5'b11110) seq_total = 3'd4;
      else begin
        emit_error(ERR_ILLEGAL);
        return;
      end
      seq_bytes = {16'd0, b};
      seq_held  = 2'd1;
      if (eob) emit_error(ERR_INCOMPLETE);
      return;
    end
    if (!extend_seq(b)) begin
      if (eob) emit_error(ERR_INCOMPLETE);
      return;
    end
    // sequence complete: check continuations, then the decoded value
    n = int'(seq_held);
    for (int i = 0; i < n; i++) s[i] = seq_bytes[8*(n-1-i) +: 8];
    s[n] = b;
    n++;
    bad = 1'b0;
    for (int i = 1; i < n; i++) if (s[i][7:6] != 2'b10) bad = 1'b1;
    if (bad) begin
      emit_error(ERR_ILLEGAL);
      return;
    end
    case (n)
      2: begin
        cp  = {10'd0, s[0][4:0], s[1][5:0]};
        bad = cp < 21'h80;
      end
      3: begin
        cp  = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
        bad = cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF);
      end
      default: begin
        cp  = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
        bad = cp < 21'h10000 || cp > 21'h10FFFF;
      end
    endcase
    if (bad) begin
      emit_error(ERR_ILLEGAL);
      return;
    end
    close_seq();
    if (cp <= 21'hFFFF) begin
      emit_byte(cp[15:8]);
      emit_byte(cp[7:0]);
    end else begin
      // surrogate pair
      v = 20'(cp - 21'h10000);
      emit_byte({6'b110110, v[19:18]});
      emit_byte(v[17:10]);
      emit_byte({6'b110111, v[9:8]});
      emit_byte(v[7:0]);
    end
  endfunction

  function automatic void decode_utf16(logic [7:0] b, logic eob);
    logic [15:0] cu;
    logic [15:0] hi;
    logic [20:0] cp;
    if (seq_total == 0) begin
      seq_bytes = {16'd0, b};
      seq_held  = 2'd1;
      seq_total = 3'd2;
      if (eob) emit_error(ERR_INCOMPLETE);
      return;
    end
    if (!extend_seq(b)) begin
      if (eob) emit_error(ERR_INCOMPLETE);
      return;
    end
    if (seq_total == 2) begin
      cu = {seq_bytes[7:0], b};
      // high surrogate opens a pair
      if (cu >= 16'hD800 && cu <= 16'hDBFF) begin
        seq_bytes = {8'd0, cu};
        seq_held  = 2'd2;
        seq_total = 3'd4;
        if (eob) emit_error(ERR_INCOMPLETE);
        return;
      end
      if (cu >= 16'hDC00 && cu <= 16'hDFFF) begin
        emit_error(ERR_ILLEGAL);
        return;
      end
      cp = {5'd0, cu};
    end else begin
      hi = seq_bytes[23:8];
      cu = {seq_bytes[7:0], b};
      if (cu < 16'hDC00 || cu > 16'hDFFF || hi < 16'hD800 || hi > 16'hDBFF) begin
        emit_error(ERR_ILLEGAL);
        return;
      end
      cp = 21'h10000 + {1'b0, hi[9:0], cu[9:0]};
    end
    close_seq();
    emit_utf8(cp);
  endfunction

  // expected results of one accepted request
  function automatic void predict_byte(in_req_t req);
    out_res_t r;
    byte_results.delete();
    case (cur_mode)
      MODE_LATIN1:   emit_utf8({13'd0, req.data_byte});
      MODE_UTF8_IN:  decode_utf8(req.data_byte, req.end_of_buffer);
      MODE_UTF16_IN: decode_utf16(req.data_byte, req.end_of_buffer);
      default:       emit_byte(req.data_byte);
    endcase
    if (byte_results.size() != 0) begin
      r = byte_results.pop_back();
      r.last_of_run = 1'b1;
      byte_results.push_back(r);
    end
    foreach (byte_results[i]) expected_q.push_back(byte_results[i]);
  endfunction

  // ---------------- driver, receiver, monitor ----------------

  // input request driver
  always @(negedge clk) begin : req_driver
    logic    nv;
    in_req_t nr;
    nv = in_valid;
    nr = in_req;
    if (rst_n) begin
      if (in_valid && in_fire) begin
        nv = 1'b0;
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        in_gap = send_burst ? 0 : $urandom_range(0, 15);
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_bytes.size() != 0) begin
          nr = pending_bytes.pop_front();
          nv = 1'b1;
        end
      end
    end
    in_valid <= nv;
    in_req   <= nr;
  end

  // long receiver hold-off
  always @(posedge clk) begin : hold_ctrl
    if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
    else if (hold_left > 0) hold_left--;
    hold_on <= (hold_left != 0);
  end

  // result receiver stalls
  always @(negedge clk) begin : res_receiver
    if (out_fire) begin
      if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
      out_wait = recv_burst ? 0 : $urandom_range(0, 15);
    end else if (out_wait > 0 && out_valid) begin
      out_wait--;
    end
    out_stall <= hold_on || (out_wait != 0);
  end

  // handshake monitor and result checker
  always @(posedge clk) begin : res_monitor
    out_res_t want;
    in_fire  = 1'b0;
    out_fire = 1'b0;
    if (!rst_n) begin
      cur_mode = MODE_COPY;
      close_seq();
    end else begin
      if (cfg_wr_en) begin
        cur_mode = cfg_wr_data;
        close_seq();
      end
      if (in_valid && !in_stall) begin
        in_fire = 1'b1;
        bytes_taken++;
        predict_byte(in_req);
      end
      if (out_valid && !out_stall) begin
        out_fire = 1'b1;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: byte %02h valid %0d err %0d last %0d",
                     out_res.out_byte, out_res.byte_valid, out_res.error_code,
                     out_res.last_of_run);
        end else begin
          want = expected_q.pop_front();
          if (out_res.out_byte !== want.out_byte || out_res.byte_valid !== want.byte_valid ||
              out_res.error_code !== want.error_code ||
              out_res.last_of_run !== want.last_of_run) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp byte %02h valid %0d err %0d last %0d, got byte %02h valid %0d err %0d last %0d",
                       want.out_byte, want.byte_valid, want.error_code, want.last_of_run,
                       out_res.out_byte, out_res.byte_valid, out_res.error_code,
                       out_res.last_of_run);
          end
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("utf_charset_transcoder_tb: FAIL");
    $finish;
  end

  // ---------------- stimulus ----------------

  task automatic queue_byte(logic [7:0] b, logic eob);
    in_req_t r;
    r.data_byte     = b;
    r.end_of_buffer = eob;
    pending_bytes.push_back(r);
    bytes_queued++;
  endtask

  // first count bytes of w, oldest in the top byte
  task automatic queue_seq(logic [31:0] w, int count, logic eob_last);
    for (int i = 0; i < count; i++)
      queue_byte(w[31-8*i -: 8], eob_last && (i == count - 1));
  endtask

  function automatic logic [31:0] utf8_form(logic [20:0] cp, int len);
    case (len)
      1: return {cp[7:0], 24'd0};
      2: return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'd0};
      3: return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'd0};
      default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                       2'b10, cp[5:0]};
    endcase
  endfunction

  // mostly well-formed utf-8, with truncated, malformed and noise bytes
  task automatic gen_utf8_unit();
    logic [31:0] w;
    logic [20:0] cp;
    logic [7:0]  junk;
    int len, sel, idx;
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: begin cp = 21'($urandom_range(0, 'h7F)); len = 1; end
      1: begin cp = 21'($urandom_range('h80, 'h7FF)); len = 2; end
      2: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp[15:11] == 5'b11011) cp = cp ^ 21'h2000;
        len = 3;
      end
      default: begin cp = 21'($urandom_range('h10000, 'h10FFFF)); len = 4; end
    endcase
    if (sel < 65) begin
      queue_seq(utf8_form(cp, len), len, $urandom_range(0, 7) == 0);
    end else if (sel < 72) begin
      // cut off by end of buffer
      len = $urandom_range(2, 4);
      queue_seq(utf8_form(cp, len), $urandom_range(1, len - 1), 1'b1);
    end else if (sel < 79) begin
      // bad continuation byte
      len  = $urandom_range(2, 4);
      w    = utf8_form(cp, len);
      idx  = $urandom_range(1, len - 1);
      junk = 8'($urandom);
      if (junk[7:6] == 2'b10) junk[6] = 1'b1;
      w[31-8*idx -: 8] = junk;
      queue_seq(w, len, 1'b0);
    end else if (sel < 85) begin
      // overlong form
      len = $urandom_range(2, 4);
      case (len)
        2: cp = 21'($urandom_range(0, 'h7F));
        3: cp = 21'($urandom_range(0, 'h7FF));
        default: cp = 21'($urandom_range(0, 'hFFFF));
      endcase
      queue_seq(utf8_form(cp, len), len, 1'b0);
    end else if (sel < 89) begin
      queue_seq(utf8_form(21'($urandom_range('hD800, 'hDFFF)), 3), 3, 1'b0);
    end else if (sel < 93) begin
      queue_seq(utf8_form(21'($urandom_range('h110000, 'h1FFFFF)), 4), 4, 1'b0);
    end else begin
      queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  // mostly well-formed utf-16be, with lone and unpaired surrogates
  task automatic gen_utf16_unit();
    logic [15:0] cu, hi, lo;
    int sel;
    sel = $urandom_range(0, 99);
    cu  = 16'($urandom_range(0, 'hFFFF));
    if (cu[15:11] == 5'b11011) cu = cu ^ 16'h2000;
    hi = 16'($urandom_range('hD800, 'hDBFF));
    lo = 16'($urandom_range('hDC00, 'hDFFF));
    if (sel < 40)      queue_seq({cu, 16'd0}, 2, $urandom_range(0, 7) == 0);
    else if (sel < 70) queue_seq({hi, lo}, 4, $urandom_range(0, 7) == 0);
    else if (sel < 77) queue_seq({lo, 16'd0}, 2, 1'b0);
    else if (sel < 84) queue_seq({hi, ($urandom_range(0, 1) != 0) ? cu : hi}, 4, 1'b0);
    else if (sel < 93) queue_seq({hi, lo}, $urandom_range(1, 3), 1'b1);
    else               queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
  endtask

  // all requests taken, all results seen, then let the block settle
  task automatic wait_idle();
    while (bytes_taken != bytes_queued || expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [1:0] plan[6];
    logic [1:0] m;
    int start;
    plan = '{MODE_COPY, MODE_UTF8_IN, MODE_LATIN1, MODE_UTF16_IN, MODE_UTF8_IN,
             MODE_UTF16_IN};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // copy mode out of reset
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    wait_idle();

    // latin-1 edges
    write_mode(MODE_LATIN1);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b1);
    wait_idle();

    // utf-8: four-byte to pair, bad lead, overlong, surrogate,
    // bad continuation, cut off at end of buffer
    write_mode(MODE_UTF8_IN);
    queue_seq(32'hF09F9880, 4, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_seq(32'hC0800000, 2, 1'b0);
    queue_seq(32'hEDA08000, 3, 1'b0);
    queue_seq(32'hC3410000, 2, 1'b0);
    queue_seq(32'hE2820000, 2, 1'b1);
    wait_idle();

    // utf-16be: lone low, high then non-low, cut off, then left open
    write_mode(MODE_UTF16_IN);
    queue_seq(32'hDC000000, 2, 1'b0);
    queue_seq(32'hD8000041, 4, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hD8, 1'b0);
    wait_idle();

    // random phases
    for (int p = 0; p < 8; p++) begin
      m = (p < 6) ? plan[p] : 2'($urandom_range(0, 3));
      write_mode(m);
      start = bytes_queued;
      while (bytes_queued - start < PHASE_BYTES) begin
        case (m)
          MODE_UTF8_IN:  gen_utf8_unit();
          MODE_UTF16_IN: gen_utf16_unit();
          default:       queue_byte(8'($urandom), $urandom_range(0, 1) != 0);
        endcase
      end
      // receiver holds off while requests keep coming
      if (p == 0) begin
        @(negedge clk);
        hold_req <= 1'b1;
        @(negedge clk);
        hold_req <= 1'b0;
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("utf_charset_transcoder_tb: PASS");
    end else begin
      $display("utf_charset_transcoder_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/utfct_pkg.sv
rtl/core/utfct_front.sv
rtl/core/utfct_queue.sv
rtl/core/utfct_back.sv
rtl/core/utf_charset_transcoder.sv
sim/utf_charset_transcoder_tb.sv
